// ===== sv/fnsw_pkg.sv =====
// Shared types, constants and the fraction step function of the synthesizer word calculator.
`default_nettype none

package fnsw_pkg;

    // Comparison frequency and rounding offset
    localparam logic [31:0] FNSW_COMP_FREQ_HZ = 32'd20000000;
    localparam logic [31:0] FNSW_ROUND_HZ     = FNSW_COMP_FREQ_HZ >> 21;

    // 20 MHz = 256 * 78125: divide the sum by 256 with a shift, then by 78125
    localparam int unsigned FNSW_LO_BITS      = 8;
    localparam logic [16:0] FNSW_DIV_HI       = 17'(FNSW_COMP_FREQ_HZ >> FNSW_LO_BITS);
    localparam logic [15:0] FNSW_RECIP        = 16'((64'd1 << 32) / 64'(FNSW_DIV_HI));

    // Fraction is built by restoring division, a few bits per pipeline stage
    localparam int unsigned FNSW_FRAC_BITS    = 20;
    localparam int unsigned FNSW_STEP_BITS    = 5;
    localparam int unsigned FNSW_FRAC_STAGES  = FNSW_FRAC_BITS / FNSW_STEP_BITS;

    // Default depth of the request queue between front and back
    localparam int unsigned FNSW_QUEUE_DEPTH  = 4;

    // Register reset values
    localparam logic [31:0] FNSW_MIN_FREQ_RST = 32'd2300000000;
    localparam logic [31:0] FNSW_MAX_FREQ_RST = 32'd2600000000;

    // Synthesizer register numbers packed into the SPI words
    localparam logic [3:0]  FNSW_SYN_REG3     = 4'd3;
    localparam logic [3:0]  FNSW_SYN_REG4     = 4'd4;

    // Configuration register index, taken from paddr[2]
    localparam logic        FNSW_REG_MIN_FREQ = 1'b0;
    localparam logic        FNSW_REG_MAX_FREQ = 1'b1;

    typedef enum logic [1:0] {
        BEAT_W3_HI,
        BEAT_W3_LO,
        BEAT_W4_HI,
        BEAT_W4_LO
    } beat_t;

    // Classified request as held in the queue
    typedef struct packed {
        logic        ok;
        logic [32:0] sum;
    } req_t;

    // Divider result handed to the result sequencer
    typedef struct packed {
        logic        ok;
        logic [7:0]  n;
        logic [19:0] frac;
    } div_res_t;

    // Handshake between divider pipeline and sequencer
    typedef struct packed {
        logic     valid;
        div_res_t res;
    } div_out_t;

    typedef struct packed {
        logic [24:0] rem;
        logic [19:0] frac;
    } frac_step_t;

    // Several restoring division steps: shift, compare, subtract
    function automatic frac_step_t frac_step(input logic [24:0] rem_in,
                                             input logic [19:0] frac_in);
        frac_step_t  r;
        logic [25:0] dbl;
        r.rem  = rem_in;
        r.frac = frac_in;
        for (int i = 0; i < int'(FNSW_STEP_BITS); i++) begin
            dbl = {r.rem, 1'b0};
            if (dbl >= 26'(FNSW_COMP_FREQ_HZ)) begin
                dbl    = dbl - 26'(FNSW_COMP_FREQ_HZ);
                r.frac = {r.frac[18:0], 1'b1};
            end
            else begin
                r.frac = {r.frac[18:0], 1'b0};
            end
            r.rem = dbl[24:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/frac_n_synth_word_calc.sv =====
// Top level of the fractional-N synthesizer word calculator.
//
//  channel   handshake                     payload
//  request   start in, busy out            lo_freq_hz
//  result    result_valid out (strobe)     freq_ok, word_present, spi_chunk,
//                                          int_divider, frac_divider, last_of_run
//  config    APB psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// A request is taken in any cycle with start high and busy low; busy rises only
// when the request queue is full. An in-window request gives four consecutive
// results, a rejected one a single result, so the result sequencer sets the
// sustained request rate. A request passes the queue, the eight divider stages
// and the sequencer before its first result. Reset restores the window registers
// and empties queue and pipeline; results are never held off.
`default_nettype none

module frac_n_synth_word_calc
    import fnsw_pkg::*;
#(
    parameter int unsigned QueueDepth = FNSW_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] lo_freq_hz,
    output logic             result_valid,
    output logic             freq_ok,
    output logic             word_present,
    output logic [8:0]       spi_chunk,
    output logic [7:0]       int_divider,
    output logic [19:0]      frac_divider,
    output logic             last_of_run,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic     q_full;
    logic     q_empty;
    logic     push;
    req_t     push_data;
    logic     pop;
    req_t     pop_data;
    div_out_t div_out;
    logic     take;

    assign busy = q_full;

    fnsw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .lo_freq_hz(lo_freq_hz),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    fnsw_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (q_empty),
        .full     (q_full)
    );

    fnsw_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(!q_empty),
        .in_data (pop_data),
        .pop     (pop),
        .out     (div_out),
        .take    (take)
    );

    fnsw_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in          (div_out),
        .take        (take),
        .result_valid(result_valid),
        .freq_ok     (freq_ok),
        .word_present(word_present),
        .spi_chunk   (spi_chunk),
        .int_divider (int_divider),
        .frac_divider(frac_divider),
        .last_of_run (last_of_run)
    );

    // A rejected request ends in one empty result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !freq_ok |-> last_of_run && !word_present && spi_chunk == '0
                                     && int_divider == '0 && frac_divider == '0)
        else $error("rejected request result malformed");

    // An accepted run continues without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && freq_ok && !last_of_run |=> result_valid && freq_ok)
        else $error("accepted run broken");

    // An accepted run ends on its fourth transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && freq_ok && last_of_run |->
            $past(result_valid, 3) && $past(freq_ok, 3) && !$past(last_of_run, 1)
            && !$past(last_of_run, 2) && !$past(last_of_run, 3))
        else $error("accepted run length wrong");

endmodule

`default_nettype wire

// ===== sv/fnsw_front.sv =====
// Front end: configuration registers, window check and request classification.
`default_nettype none

module fnsw_front
    import fnsw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] lo_freq_hz,
    input  wire logic        q_full,
    output logic             push,
    output req_t             push_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] min_freq_reg;
    logic [31:0] max_freq_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_freq_reg <= FNSW_MIN_FREQ_RST;
            max_freq_reg <= FNSW_MAX_FREQ_RST;
        end
        else if (wr_en) begin
            unique case (paddr[2])
                FNSW_REG_MIN_FREQ: min_freq_reg <= pwdata;
                FNSW_REG_MAX_FREQ: max_freq_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            FNSW_REG_MIN_FREQ: prdata = min_freq_reg;
            FNSW_REG_MAX_FREQ: prdata = max_freq_reg;
            default:           prdata = '0;
        endcase
    end

    // Classify at accept: window check and rounded sum, no wrap
    assign push          = start && !q_full;
    assign push_data.ok  = (lo_freq_hz >= min_freq_reg) && (lo_freq_hz <= max_freq_reg);
    assign push_data.sum = {1'b0, lo_freq_hz} + {1'b0, FNSW_ROUND_HZ};

endmodule

`default_nettype wire

// ===== sv/fnsw_queue.sv =====
// Short request queue between the front end and the divider pipeline.
`default_nettype none

module fnsw_queue
    import fnsw_pkg::*;
#(
    parameter int unsigned Depth = FNSW_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire req_t push_data,
    input  wire logic pop,
    output req_t      pop_data,
    output logic      empty,
    output logic      full
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    req_t              mem_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CntW'(Depth));
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fnsw_div.sv =====
// Divider pipeline: integer divider by reciprocal multiply, fraction by restoring division.
`default_nettype none

module fnsw_div
    import fnsw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire req_t in_data,
    output logic      pop,
    output div_out_t  out,
    input  wire logic take
);

    localparam int unsigned NumStages = 4 + FNSW_FRAC_STAGES;

    logic [NumStages-1:0] v_reg;
    logic [NumStages:0]   en;

    // Stage 0: split sum into sum/256 and the low byte
    logic        s0_ok_reg;
    logic [24:0] s0_x_reg;
    logic [7:0]  s0_lo_reg;
    // Stage 1: quotient estimate, at most one low
    logic        s1_ok_reg;
    logic [24:0] s1_x_reg;
    logic [7:0]  s1_lo_reg;
    logic [8:0]  s1_q_reg;
    // Stage 2: partial remainder below twice the divisor
    logic        s2_ok_reg;
    logic [7:0]  s2_lo_reg;
    logic [8:0]  s2_q_reg;
    logic [17:0] s2_r_reg;
    // Stage 3: corrected integer divider and remainder
    logic        s3_ok_reg;
    logic [7:0]  s3_n_reg;
    logic [24:0] s3_rem_reg;
    // Fraction stages
    logic        fs_ok_reg   [FNSW_FRAC_STAGES];
    logic [7:0]  fs_n_reg    [FNSW_FRAC_STAGES];
    logic [24:0] fs_rem_reg  [FNSW_FRAC_STAGES];
    logic [19:0] fs_frac_reg [FNSW_FRAC_STAGES];

    logic [40:0] prod1;
    logic [25:0] prod2;
    logic [25:0] diff2;
    logic        corr3;
    logic [8:0]  n3;
    logic [17:0] r3;

    logic        src_ok   [FNSW_FRAC_STAGES];
    logic [7:0]  src_n    [FNSW_FRAC_STAGES];
    frac_step_t  src_step [FNSW_FRAC_STAGES];
    frac_step_t  dst_step [FNSW_FRAC_STAGES];

    // A stage loads when it is empty or its successor moves on
    always_comb begin
        en[NumStages] = take;
        for (int k = NumStages - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign pop = en[0] && in_valid;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < int'(NumStages); k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign prod1 = 41'(s0_x_reg) * 41'(FNSW_RECIP);
    assign prod2 = 26'(s1_q_reg) * 26'(FNSW_DIV_HI);
    assign diff2 = 26'(s1_x_reg) - prod2;
    assign corr3 = (s2_r_reg >= 18'(FNSW_DIV_HI));
    assign n3    = corr3 ? s2_q_reg + 1'b1 : s2_q_reg;
    assign r3    = corr3 ? s2_r_reg - 18'(FNSW_DIV_HI) : s2_r_reg;

    always_comb begin
        for (int j = 0; j < int'(FNSW_FRAC_STAGES); j++) begin
            if (j == 0) begin
                src_ok[j]        = s3_ok_reg;
                src_n[j]         = s3_n_reg;
                src_step[j].rem  = s3_rem_reg;
                src_step[j].frac = '0;
            end
            else begin
                src_ok[j]        = fs_ok_reg[j-1];
                src_n[j]         = fs_n_reg[j-1];
                src_step[j].rem  = fs_rem_reg[j-1];
                src_step[j].frac = fs_frac_reg[j-1];
            end
            dst_step[j] = frac_step(src_step[j].rem, src_step[j].frac);
        end
    end

    always_ff @(posedge clk) begin
        if (en[0]) begin
            s0_ok_reg <= in_data.ok;
            s0_x_reg  <= in_data.sum[32:FNSW_LO_BITS];
            s0_lo_reg <= in_data.sum[FNSW_LO_BITS-1:0];
        end
        if (en[1]) begin
            s1_ok_reg <= s0_ok_reg;
            s1_x_reg  <= s0_x_reg;
            s1_lo_reg <= s0_lo_reg;
            s1_q_reg  <= prod1[40:32];
        end
        if (en[2]) begin
            s2_ok_reg <= s1_ok_reg;
            s2_lo_reg <= s1_lo_reg;
            s2_q_reg  <= s1_q_reg;
            s2_r_reg  <= diff2[17:0];
        end
        if (en[3]) begin
            s3_ok_reg  <= s2_ok_reg;
            s3_n_reg   <= n3[7:0];
            s3_rem_reg <= {r3[16:0], s2_lo_reg};
        end
        for (int j = 0; j < int'(FNSW_FRAC_STAGES); j++) begin
            if (en[4+j]) begin
                fs_ok_reg[j]   <= src_ok[j];
                fs_n_reg[j]    <= src_n[j];
                fs_rem_reg[j]  <= dst_step[j].rem;
                fs_frac_reg[j] <= dst_step[j].frac;
            end
        end
    end

    // Rejected requests carry zero dividers
    assign out.valid    = v_reg[NumStages-1];
    assign out.res.ok   = fs_ok_reg[FNSW_FRAC_STAGES-1];
    assign out.res.n    = fs_ok_reg[FNSW_FRAC_STAGES-1] ? fs_n_reg[FNSW_FRAC_STAGES-1] : '0;
    assign out.res.frac = fs_ok_reg[FNSW_FRAC_STAGES-1] ?
                          fs_frac_reg[FNSW_FRAC_STAGES-1] : '0;

endmodule

`default_nettype wire

// ===== sv/fnsw_seq.sv =====
// Result sequencer: splits the two synthesizer words of an accepted request into four 9-bit SPI transfers.
`default_nettype none

module fnsw_seq
    import fnsw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_out_t in,
    output logic          take,
    output logic          result_valid,
    output logic          freq_ok,
    output logic          word_present,
    output logic [8:0]    spi_chunk,
    output logic [7:0]    int_divider,
    output logic [19:0]   frac_divider,
    output logic          last_of_run
);

    logic     active_reg;
    logic     active_next;
    beat_t    beat_reg;
    beat_t    beat_next;
    div_res_t res_reg;
    logic     done;

    logic [17:0] w3;
    logic [17:0] w4;

    assign done = active_reg && (!res_reg.ok || beat_reg == BEAT_W4_LO);
    assign take = !active_reg || done;

    always_comb begin
        active_next = active_reg;
        beat_next   = beat_reg;
        if (take) begin
            active_next = in.valid;
            beat_next   = BEAT_W3_HI;
        end
        else begin
            unique case (beat_reg)
                BEAT_W3_HI: beat_next = BEAT_W3_LO;
                BEAT_W3_LO: beat_next = BEAT_W4_HI;
                BEAT_W4_HI: beat_next = BEAT_W4_LO;
                BEAT_W4_LO: beat_next = BEAT_W4_LO;
                default:    beat_next = BEAT_W3_HI;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            beat_reg   <= BEAT_W3_HI;
        end
        else begin
            active_reg <= active_next;
            beat_reg   <= beat_next;
        end
    end

    always_ff @(posedge clk) begin
        if (take && in.valid) begin
            res_reg <= in.res;
        end
    end

    assign w3 = {res_reg.frac[5:0], res_reg.n, FNSW_SYN_REG3};
    assign w4 = {res_reg.frac[19:6], FNSW_SYN_REG4};

    always_comb begin
        unique case (beat_reg)
            BEAT_W3_HI: spi_chunk = w3[17:9];
            BEAT_W3_LO: spi_chunk = w3[8:0];
            BEAT_W4_HI: spi_chunk = w4[17:9];
            BEAT_W4_LO: spi_chunk = w4[8:0];
            default:    spi_chunk = '0;
        endcase
        if (!res_reg.ok) begin
            spi_chunk = '0;
        end
    end

    assign result_valid = active_reg;
    assign freq_ok      = res_reg.ok;
    assign word_present = res_reg.ok;
    assign int_divider  = res_reg.n;
    assign frac_divider = res_reg.frac;
    assign last_of_run  = done;

endmodule

`default_nettype wire

// ===== tb/sv/tb_frac_n_synth_word_calc.sv =====
// Testbench for the synthesizer word calculator: window checks, divider math and SPI packing.
`default_nettype none

module tb_frac_n_synth_word_calc;
    import fnsw_pkg::*;

    localparam logic [31:0] COMP_HZ       = 32'd20000000;
    localparam logic [31:0] ROUND_HZ      = COMP_HZ >> 21;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          PHASE_ITEMS   = 63;

    typedef struct packed {
        logic        ok;
        logic        present;
        logic [8:0]  chunk;
        logic [7:0]  n;
        logic [19:0] frac;
        logic        last;
    } synth_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] lo_freq_hz;
    logic        result_valid;
    logic        freq_ok;
    logic        word_present;
    logic [8:0]  spi_chunk;
    logic [7:0]  int_divider;
    logic [19:0] frac_divider;
    logic        last_of_run;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    synth_word_t pending_words[$];
    logic [31:0] win_lo;
    logic [31:0] win_hi;
    int          idle_pct;
    int          errors;
    int          n_in_window;
    int          n_rejected;
    int          n_results;
    int          quiet_cycles;

    frac_n_synth_word_calc dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .lo_freq_hz   (lo_freq_hz),
        .result_valid (result_valid),
        .freq_ok      (freq_ok),
        .word_present (word_present),
        .spi_chunk    (spi_chunk),
        .int_divider  (int_divider),
        .frac_divider (frac_divider),
        .last_of_run  (last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Expected SPI transfers for one frequency request
    function automatic void predict_words(input logic [31:0] f);
        synth_word_t w;
        logic [32:0] sum;
        logic [7:0]  n;
        logic [25:0] rem;
        logic [19:0] frac;
        logic [17:0] w3;
        logic [17:0] w4;
        if (f < win_lo || f > win_hi) begin
            w      = '0;
            w.last = 1'b1;
            pending_words.push_back(w);
            n_rejected++;
            return;
        end
        sum  = {1'b0, f} + 33'(ROUND_HZ);
        n    = 8'(sum / 33'(COMP_HZ));
        rem  = 26'(sum % 33'(COMP_HZ));
        frac = '0;
        for (int i = 0; i < 20; i++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= 26'(COMP_HZ)) begin
                frac[0] = 1'b1;
                rem     = rem - 26'(COMP_HZ);
            end
        end
        w3 = {frac[5:0], n, FNSW_SYN_REG3};
        w4 = {frac[19:6], FNSW_SYN_REG4};
        w  = '{ok: 1'b1, present: 1'b1, chunk: w3[17:9], n: n, frac: frac, last: 1'b0};
        pending_words.push_back(w);
        w.chunk = w3[8:0];
        pending_words.push_back(w);
        w.chunk = w4[17:9];
        pending_words.push_back(w);
        w.chunk = w4[8:0];
        w.last  = 1'b1;
        pending_words.push_back(w);
        n_in_window++;
    endfunction

    function automatic void check_field(input string name, input longint unsigned exp_v,
                                        input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Result checker: results cannot be held off, so every strobe is taken
    always @(posedge clk) begin
        synth_word_t w;
        if (rst_n && result_valid) begin
            n_results++;
            if (pending_words.size() == 0) begin
                $error("unexpected result: spi_chunk 0x%0h freq_ok %0d", spi_chunk, freq_ok);
                errors++;
            end
            else begin
                w = pending_words.pop_front();
                check_field("freq_ok", w.ok, freq_ok);
                check_field("word_present", w.present, word_present);
                check_field("spi_chunk", w.chunk, spi_chunk);
                check_field("int_divider", w.n, int_divider);
                check_field("frac_divider", w.frac, frac_divider);
                check_field("last_of_run", w.last, last_of_run);
            end
        end
    end

    // Watchdog on cycles with no request, result or register access
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // All tasks are entered and left just after a rising edge
    task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] data,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_window_reg(input logic idx, input logic [31:0] val);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, val, rd);
        apb_xfer(1'b0, idx, '0, rd);
        check_field(idx == FNSW_REG_MIN_FREQ ? "min_freq_hz" : "max_freq_hz", val, rd);
    endtask

    // Drop start and hold until every expected result is back, then let the pipe settle
    task automatic drain_results();
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
        drain_results();
        write_window_reg(FNSW_REG_MIN_FREQ, lo);
        win_lo = lo;
        write_window_reg(FNSW_REG_MAX_FREQ, hi);
        win_hi = hi;
    endtask

    task automatic send_freq(input logic [31:0] f);
        int gap;
        start      <= 1'b1;
        lo_freq_hz <= f;
        do @(posedge clk); while (busy);
        predict_words(f);
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_in_window();
        logic [31:0] a;
        logic [31:0] b;
        a = (win_lo <= win_hi) ? win_lo : win_hi;
        b = (win_lo <= win_hi) ? win_hi : win_lo;
        if (a == 32'd0 && b == 32'hFFFF_FFFF)
            return $urandom();
        return $urandom_range(b, a);
    endfunction

    function automatic logic [31:0] pick_freq();
        int r;
        r = $urandom_range(9);
        if (r <= 5)
            return pick_in_window();
        else if (r <= 7) begin
            case ($urandom_range(5))
                0: return win_lo;
                1: return win_hi;
                2: return win_lo - 32'd1;
                3: return win_hi + 32'd1;
                4: return win_lo + 32'd1;
                default: return win_hi - 32'd1;
            endcase
        end
        return $urandom();
    endfunction

    task automatic test_reset_window();
        idle_pct = 0;
        send_freq(32'd2300000000);
        send_freq(32'd2299999999);
        send_freq(32'd2600000000);
        send_freq(32'd2600000001);
        send_freq(32'd0);
        send_freq(32'hFFFF_FFFF);
        // rounding offset carries into the next integer divider
        send_freq(32'd2399999991);
        send_freq(32'd2399999990);
    endtask

    task automatic test_full_range();
        set_window(32'd0, 32'hFFFF_FFFF);
        idle_pct = 49;
        send_freq(32'd0);
        send_freq(32'hFFFF_FFFF);
        send_freq(32'd19999991);
        send_freq(32'd19999990);
        send_freq(32'hAAAA_AAAA);
        send_freq(32'h5555_5555);
    endtask

    task automatic test_inverted_window();
        set_window(32'd2600000000, 32'd2300000000);
        idle_pct = 22;
        send_freq(32'd2300000000);
        send_freq(32'd2450000000);
        send_freq(32'd2600000000);
        send_freq(32'd0);
    endtask

    task automatic test_single_point_window();
        set_window(32'd2412345678, 32'd2412345678);
        idle_pct = 0;
        send_freq(32'd2412345677);
        send_freq(32'd2412345678);
        send_freq(32'd2412345679);
    endtask

    task automatic test_random_traffic();
        logic [31:0] a;
        logic [31:0] b;
        for (int phase = 0; phase < 8; phase++) begin
            a = $urandom();
            b = $urandom();
            case (phase)
                0: set_window(FNSW_MIN_FREQ_RST, FNSW_MAX_FREQ_RST);
                1: set_window(32'd0, 32'hFFFF_FFFF);
                2: set_window(a < b ? a : b, a < b ? b : a);
                3: set_window(a, (a + 32'd200000000 < a) ? 32'hFFFF_FFFF : a + 32'd200000000);
                4: set_window(a > b ? a : b, a > b ? b : a);
                5: set_window(32'd0, b);
                6: set_window(a, 32'hFFFF_FFFF);
                default: set_window(32'd0, 32'hFFFF_FFFF);
            endcase
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 49;
                2: idle_pct = 22;
                default: idle_pct = 49;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_freq(pick_freq());
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        start      = 1'b0;
        lo_freq_hz = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        win_lo     = FNSW_MIN_FREQ_RST;
        win_hi     = FNSW_MAX_FREQ_RST;
        idle_pct   = 0;
        errors     = 0;
        n_in_window = 0;
        n_rejected  = 0;
        n_results   = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_full_range();
        test_inverted_window();
        test_single_point_window();
        test_random_traffic();
        drain_results();

        $display("Requests: %0d in window, %0d rejected; %0d SPI results checked",
                 n_in_window, n_rejected, n_results);
        $display("Windows: reset, full range, inverted, single point and random bounds");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
